// File: rtl/ibs_pkg.sv
package ibs_pkg;

   localparam int VARINT_MAX_BYTES = 10;
   localparam int VALUE_W = 64;
   localparam int VALUE_GROUPS = (VALUE_W + 6) / 7;
   localparam int VBUF_W = 7 * VARINT_MAX_BYTES;
   localparam int DATA_W = (VBUF_W > VALUE_W) ? VBUF_W : VALUE_W;
   localparam int SHIFT_W = $clog2(DATA_W);
   localparam int CNT_W = $clog2(VALUE_GROUPS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_LITTLE = 2'd0;
   localparam logic [1:0] OP_BIG = 2'd1;
   localparam logic [1:0] OP_NATIVE = 2'd2;
   localparam logic [1:0] OP_VARINT = 2'd3;

   localparam logic [1:0] SIZE_1 = 2'd0;
   localparam logic [1:0] SIZE_2 = 2'd1;
   localparam logic [1:0] SIZE_4 = 2'd2;
   localparam logic [1:0] SIZE_8 = 2'd3;

   typedef enum logic [2:0] {
      FMT_LE = 3'b001,
      FMT_BE = 3'b010,
      FMT_VAR = 3'b100
   } fmt_type;

   typedef struct packed {
      fmt_type fmt;
      logic [CNT_W-1:0] count;
      logic [DATA_W-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
   } q_out_type;

endpackage

// File: rtl/ibs_front.sv
module ibs_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_opcode,
   input logic [1:0] req_size_code,
   input logic [63:0] req_value,
   input logic csr_wr_en,
   input logic csr_wr_data,
   input logic q_full,
   output logic q_push,
   output ibs_pkg::cmd_type q_cmd
);
   import ibs_pkg::*;

   logic native_big_ff, native_big_in;
   logic big;
   logic [CNT_W-1:0] groups;
   logic [CNT_W-1:0] fixed_count;
   logic [CNT_W-1:0] var_diff;
   logic [SHIFT_W-1:0] be_shift;
   logic [SHIFT_W-1:0] var_shift;
   logic [DATA_W-1:0] wide_value;

   assign native_big_in = csr_wr_en ? csr_wr_data : native_big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         native_big_ff <= 1'b0;
      end else begin
         native_big_ff <= native_big_in;
      end
   end

   assign req_ready = !q_full;
   assign q_push = req_valid && req_ready;
   assign wide_value = DATA_W'(req_value);
   assign big = (req_opcode == OP_BIG) || ((req_opcode == OP_NATIVE) && native_big_ff);

   always_comb begin
      unique case (req_size_code)
         SIZE_1: begin
            fixed_count = CNT_W'(1);
            be_shift = SHIFT_W'(56);
         end
         SIZE_2: begin
            fixed_count = CNT_W'(2);
            be_shift = SHIFT_W'(48);
         end
         SIZE_4: begin
            fixed_count = CNT_W'(4);
            be_shift = SHIFT_W'(32);
         end
         default: begin
            fixed_count = CNT_W'(8);
            be_shift = SHIFT_W'(0);
         end
      endcase
   end

   // Number of significant 7-bit groups, at least one, capped at the buffer size.
   always_comb begin
      groups = CNT_W'(1);
      for (int g = 1; g < VALUE_GROUPS; g++) begin
         if ((req_value >> (7 * g)) != 64'd0) begin
            groups = CNT_W'(g + 1);
         end
      end
      if (groups > CNT_W'(VARINT_MAX_BYTES)) begin
         groups = CNT_W'(VARINT_MAX_BYTES);
      end
   end

   assign var_diff = CNT_W'(VARINT_MAX_BYTES) - groups;
   assign var_shift = SHIFT_W'(SHIFT_W'(var_diff) * SHIFT_W'(7));

   always_comb begin
      if (req_opcode == OP_VARINT) begin
         q_cmd.fmt = FMT_VAR;
         q_cmd.count = groups;
         q_cmd.data = wide_value << var_shift;
      end else if (big) begin
         q_cmd.fmt = FMT_BE;
         q_cmd.count = fixed_count;
         q_cmd.data = wide_value << be_shift;
      end else begin
         q_cmd.fmt = FMT_LE;
         q_cmd.count = fixed_count;
         q_cmd.data = wide_value;
      end
   end

endmodule

// File: rtl/ibs_queue.sv
module ibs_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input ibs_pkg::cmd_type push_cmd,
   output logic full,
   input logic pop,
   output ibs_pkg::q_out_type q_out
);
   import ibs_pkg::*;

   cmd_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_pop = pop && (count_ff != '0);
   assign q_out.valid = (count_ff != '0);
   assign q_out.cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/ibs_back.sv
module ibs_back (
   input logic clock,
   input logic reset,
   input ibs_pkg::q_out_type q_out,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_last
);
   import ibs_pkg::*;

   logic active_ff, active_in;
   fmt_type fmt_ff, fmt_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic last_ff, last_in;
   logic out_free;
   logic emit;
   logic final_byte;
   logic [7:0] cur_byte;
   logic [DATA_W-1:0] shifted;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit = active_ff && out_free;
   assign final_byte = (rem_ff == CNT_W'(1));
   assign pop = q_out.valid && (!active_ff || (emit && final_byte));

   always_comb begin
      unique case (fmt_ff)
         FMT_LE: begin
            cur_byte = data_ff[7:0];
            shifted = data_ff >> 8;
         end
         FMT_BE: begin
            cur_byte = data_ff[63:56];
            shifted = data_ff << 8;
         end
         default: begin
            cur_byte = {!final_byte, data_ff[VBUF_W-1 -: 7]};
            shifted = data_ff << 7;
         end
      endcase
   end

   always_comb begin
      active_in = active_ff;
      fmt_in = fmt_ff;
      rem_in = rem_ff;
      data_in = data_ff;
      if (emit) begin
         rem_in = rem_ff - 1'b1;
         data_in = shifted;
         if (final_byte) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         fmt_in = q_out.cmd.fmt;
         rem_in = q_out.cmd.count;
         data_in = q_out.cmd.data;
      end
   end

   always_comb begin
      byte_in = byte_ff;
      last_in = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         byte_in = cur_byte;
         last_in = final_byte;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fmt_ff <= FMT_LE;
      end else begin
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         fmt_ff <= fmt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      data_ff <= data_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last = last_ff;

endmodule

// File: rtl/integer_byte_serializer.sv
// The first byte of a word passes through the queue, the back-end shift register and the output register to rsp.
// Bytes then leave at one per cycle while the receiver keeps rsp_ready high.
// The output register and the byte shifter in the back end set that rate of one byte a cycle.
// A two-entry queue lets new words be accepted while earlier ones are still being sent.
// Reset is synchronous and active high; it empties the queue and clears native order.
module integer_byte_serializer (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_opcode,
   input logic [1:0] req_size_code,
   input logic [63:0] req_value,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic rsp_last,
   input logic csr_wr_en,
   input logic csr_wr_data
);
   import ibs_pkg::*;

   logic q_full;
   logic q_push;
   logic q_pop;
   cmd_type q_cmd;
   q_out_type q_out;

   ibs_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_size_code(req_size_code),
      .req_value(req_value),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(q_cmd)
   );

   ibs_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_cmd(q_cmd),
      .full(q_full),
      .pop(q_pop),
      .q_out(q_out)
   );

   ibs_back u_back (
      .clock(clock),
      .reset(reset),
      .q_out(q_out),
      .pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last)
   );

endmodule

// File: rtl/ibs_checker.sv
module ibs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic rsp_last
);

   logic [2:0] pending_ff, pending_in;
   logic req_fire;
   logic rsp_done;

   assign req_fire = req_valid && req_ready;
   assign rsp_done = rsp_valid && rsp_ready && rsp_last;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_done) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_done && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("output word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled output word changed");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("output word with no word outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd4 |-> !req_ready)
      else $error("input accepted beyond buffering capacity");

endmodule

bind integer_byte_serializer ibs_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_out_byte(rsp_out_byte),
   .rsp_last(rsp_last)
);

// File: bench/ibs_checker.sv
`timescale 1ns / 1ps

module tb_checker
   import ibs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic [1:0] req_opcode,
   input logic [1:0] req_size_code,
   input logic [63:0] req_value,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic rsp_last,
   input logic csr_wr_en,
   input logic csr_wr_data,
   output int mismatch_count,
   output int bytes_owed
);

   typedef struct packed {
      logic [7:0] data;
      logic last;
   } coded_byte_type;

   coded_byte_type coded_bytes[$];
   logic native_big = 1'b0;
   int errors = 0;
   int owed = 0;

   assign mismatch_count = errors;
   assign bytes_owed = owed;

   function automatic void push_fixed(logic [63:0] value, logic [1:0] size_code, logic big);
      int n;
      int pos;
      coded_byte_type cb;
      n = 1 << size_code;
      for (int i = 0; i < n; i++) begin
         pos = big ? n - 1 - i : i;
         cb.data = value[8 * pos +: 8];
         cb.last = (i == n - 1);
         coded_bytes.push_back(cb);
      end
   endfunction

   function automatic void push_varint(logic [63:0] value);
      int groups;
      logic [63:0] rest;
      logic [63:0] group_bits;
      coded_byte_type cb;
      groups = 1;
      rest = value >> 7;
      while (rest != 0) begin
         groups++;
         rest = rest >> 7;
      end
      if (groups > VARINT_MAX_BYTES) begin
         groups = VARINT_MAX_BYTES;
      end
      for (int g = groups - 1; g >= 0; g--) begin
         group_bits = value >> (7 * g);
         cb.data = {(g != 0), group_bits[6:0]};
         cb.last = (g == 0);
         coded_bytes.push_back(cb);
      end
   endfunction

   function automatic void encode_word(logic [1:0] opcode, logic [1:0] size_code,
                                       logic [63:0] value);
      case (opcode)
         OP_LITTLE: push_fixed(value, size_code, 1'b0);
         OP_BIG: push_fixed(value, size_code, 1'b1);
         OP_NATIVE: push_fixed(value, size_code, native_big);
         default: push_varint(value);
      endcase
   endfunction

   always @(posedge clock) begin : watch
      coded_byte_type head;
      if (reset) begin
         native_big = 1'b0;
         coded_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (coded_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, got byte %02h last %0b",
                        $time, rsp_out_byte, rsp_last);
            end else begin
               head = coded_bytes.pop_front();
               if (rsp_out_byte !== head.data) begin
                  errors++;
                  $display("%0t: out_byte mismatch, expected %02h, got %02h",
                           $time, head.data, rsp_out_byte);
               end
               if (rsp_last !== head.last) begin
                  errors++;
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, head.last, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_word(req_opcode, req_size_code, req_value);
         end
         if (csr_wr_en) begin
            native_big = csr_wr_data;
         end
      end
      owed = coded_bytes.size();
   end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ibs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [1:0] req_opcode;
   logic [1:0] req_size_code;
   logic [63:0] req_value;
   logic rsp_valid;
   logic rsp_ready;
   logic [7:0] rsp_out_byte;
   logic rsp_last;
   logic csr_wr_en;
   logic csr_wr_data;

   int mismatch_count;
   int bytes_owed;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;

   integer_byte_serializer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_size_code(req_size_code),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   tb_checker i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_size_code(req_size_code),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count),
      .bytes_owed(bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // A nonzero hold-off keeps the receiver stalled until it has counted down to zero.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_word(logic [1:0] opcode, logic [1:0] size_code, logic [63:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= opcode;
      req_size_code <= size_code;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_word();
      logic [63:0] value;
      case ($urandom_range(3))
         0: value = {$urandom, $urandom};
         1: value = {$urandom, $urandom} >> $urandom_range(63);
         2: value = 64'($urandom_range(300));
         default: value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
      endcase
      send_word(2'($urandom_range(3)), 2'($urandom_range(3)), value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (bytes_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_native_order(logic big);
      csr_wr_en <= 1'b1;
      csr_wr_data <= big;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int idle_pct, int stall, int count);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      repeat (count) send_random_word();
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_LITTLE;
      req_size_code <= SIZE_1;
      req_value <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      for (int op = 0; op < 3; op++) begin
         for (int sz = 0; sz < 4; sz++) begin
            send_word(2'(op), 2'(sz), 64'h0123_4567_89ab_cdef);
         end
      end
      send_word(OP_LITTLE, SIZE_8, '1);
      send_word(OP_BIG, SIZE_8, '0);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'd0);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'd127);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'd128);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'd16383);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'd16384);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'h7fff_ffff_ffff_ffff);
      send_word(OP_VARINT, 2'($urandom_range(3)), 64'h8000_0000_0000_0000);
      send_word(OP_VARINT, 2'($urandom_range(3)), '1);
      drain();

      set_native_order(1'b1);
      send_word(OP_NATIVE, SIZE_4, 64'h0123_4567_89ab_cdef);
      send_word(OP_NATIVE, SIZE_8, 64'h0123_4567_89ab_cdef);
      random_phase(0, 0, 75);

      set_native_order(1'b0);
      random_phase(83, 0, 75);

      set_native_order(1'b1);
      random_phase(0, 83, 75);

      // The receiver stalls long enough for the queue to fill and block new words.
      hold_left = 400;
      random_phase(0, 0, 20);

      set_native_order(1'b0);
      random_phase(20, 20, 75);

      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
